// ===== sv/ir_pulse_width_capture_macros.svh =====
// Assertion macros for the infrared pulse width capture block.
`ifndef IR_PULSE_WIDTH_CAPTURE_MACROS_SVH
`define IR_PULSE_WIDTH_CAPTURE_MACROS_SVH

`ifndef SYNTHESIS
// Checks a property on every clock edge outside reset.
`define IPWC_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) else $error(msg);
// Checks that a condition implies a consequence in the same cycle.
`define IPWC_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error(msg);
`else
`define IPWC_ASSERT(lbl, clk_i, rstn_i, prop, msg)
`define IPWC_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons, msg)
`endif

`endif

// ===== sv/ipwc_pkg.sv =====
// Shared types, codes and default sizes for the infrared pulse width capture block.
package ipwc_pkg;

  // Default sizes of the capture buffer and the tick counter.
  localparam int IPWC_BUF_DEPTH  = 128;
  localparam int IPWC_TICK_WIDTH = 16;

  // Field widths of the transactions and of the configuration port.
  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 7;
  localparam int PHASE_W    = 2;
  localparam int COUNT_W    = 8;
  localparam int VALUE_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int GAP_W      = 16;

  // Action codes of an input transaction.
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  // Phase codes reported in a result transaction.
  localparam logic [PHASE_W-1:0] PHASE_LISTEN = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_MARK   = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_SPACE  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_DONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_LEVEL = 1'd1;

endpackage

// ===== sv/ipwc_in_if.sv =====
// Input channel: valid/ready handshake carrying action, level and index.
interface ipwc_in_if import ipwc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACTION_W-1:0] action;
  logic               level;
  logic [INDEX_W-1:0]  index;

  modport source (output valid, output action, output level, output index, input ready);
  modport sink (input valid, input action, input level, input index, output ready);
endinterface

// ===== sv/ipwc_out_if.sv =====
// Result channel: valid/ready handshake carrying status and entry value.
interface ipwc_out_if import ipwc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0]  phase;
  logic [COUNT_W-1:0]  count;
  logic               overflow_error;
  logic [VALUE_W-1:0]  entry_value;

  modport source (output valid, output phase, output count, output overflow_error,
                  output entry_value, input ready);
  modport sink (input valid, input phase, input count, input overflow_error,
                input entry_value, output ready);
endinterface

// ===== sv/ipwc_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module ipwc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ir_pulse_width_capture.sv =====
// Top level of the infrared pulse width capture block: mark/space timing and buffer.
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid/ready        action, level, index
//   out_ch    source     valid/ready        phase, count, overflow_error, entry_value
//   cfg_*     input      cfg_we, no wait    cfg_index, cfg_wdata
//
// One transaction is accepted every cycle while the result path does not stall; its result appears
// after the registered read of the duration buffer and the output register.
// The state update of a transaction completes in the cycle of its acceptance.
// Reset is synchronous and clears all control state; the buffer needs no clearing.
// A stalled result register holds while one more transaction is accepted behind it.
`include "ir_pulse_width_capture_macros.svh"

module ir_pulse_width_capture import ipwc_pkg::*; #(
  parameter int BUF_DEPTH  = IPWC_BUF_DEPTH,
  parameter int TICK_WIDTH = IPWC_TICK_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ipwc_in_if.sink               in_ch,
  ipwc_out_if.source            out_ch
);

  localparam int AW    = $clog2(BUF_DEPTH);
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int XW    = (AW > INDEX_W) ? AW : INDEX_W;
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    PH_LISTEN_S = 4'b0001,
    PH_MARK_S   = 4'b0010,
    PH_SPACE_S  = 4'b0100,
    PH_DONE_S   = 4'b1000
  } phase_state_t;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_state_t ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_LISTEN_S: code = PHASE_LISTEN;
      PH_MARK_S:   code = PHASE_MARK;
      PH_SPACE_S:  code = PHASE_SPACE;
      PH_DONE_S:   code = PHASE_DONE;
      default:     code = PHASE_LISTEN;
    endcase
    return code;
  endfunction

  // Configuration and capture state.
  logic [GAP_W-1:0]      min_gap_r;
  logic                  mark_level_r;
  phase_state_t          phase_r, phase_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TICK_WIDTH-1:0] tick_r, tick_nxt;
  logic                  err_r, err_nxt;

  // Pipeline stage waiting on the buffer read, then the output register.
  logic                  p_v_r;
  logic [PHASE_W-1:0]    p_phase_r;
  logic [COUNT_W-1:0]    p_cnt_r;
  logic                  p_err_r;
  logic                  p_rd_r;
  logic                  o_v_r;
  logic [PHASE_W-1:0]    o_phase_r;
  logic [COUNT_W-1:0]    o_cnt_r;
  logic                  o_err_r;
  logic [VALUE_W-1:0]    o_val_r;

  logic                  in_acc;
  logic                  p_adv;
  logic                  is_mark;
  logic                  full;
  logic                  in_frame;
  logic [TICK_WIDTH-1:0] tick_inc;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [TICK_WIDTH-1:0] ram_rdata;
  logic [XW-1:0]         idx_x;
  logic                  rd_hit;
  logic [31:0]           cnt_ext;
  logic [31:0]           rd_ext;

  // Handshake: the read stage frees up whenever its transaction moves on.
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign p_adv       = p_v_r && (!o_v_r || out_ch.ready);
  assign in_ch.ready = !p_v_r || p_adv;

  // Sample classification and saturating tick increment.
  assign is_mark  = (in_ch.level == mark_level_r);
  assign tick_inc = (tick_r == TICK_MAX) ? tick_r : tick_r + TICK_WIDTH'(1);
  assign full     = 32'(cnt_r) >= 32'(BUF_DEPTH);
  assign in_frame = (phase_r == PH_MARK_S) || (phase_r == PH_SPACE_S);

  // Read address and range check against the current entry count.
  assign idx_x     = XW'(in_ch.index);
  assign ram_raddr = idx_x[AW-1:0];
  assign rd_hit    = (32'(in_ch.index) < 32'(cnt_r)) && (32'(in_ch.index) < 32'(BUF_DEPTH));

  // Next capture state for the accepted transaction.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    tick_nxt  = tick_r;
    err_nxt   = err_r;
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_re    = 1'b0;
    if (in_acc) begin
      case (in_ch.action)
        ACT_TICK: begin
          tick_nxt = tick_inc;
          if (full) begin
            err_nxt   = 1'b1;
            phase_nxt = PH_DONE_S;
          end else begin
            unique case (phase_r)
              PH_LISTEN_S: begin
                if (is_mark) begin
                  tick_nxt = '0;
                  if (32'(tick_inc) >= 32'(min_gap_r)) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    cnt_nxt   = CNT_W'(1);
                    err_nxt   = 1'b0;
                    phase_nxt = PH_MARK_S;
                  end
                end
              end
              PH_MARK_S: begin
                if (!is_mark) begin
                  ram_we    = 1'b1;
                  cnt_nxt   = cnt_r + CNT_W'(1);
                  tick_nxt  = '0;
                  phase_nxt = PH_SPACE_S;
                end
              end
              PH_SPACE_S: begin
                if (is_mark) begin
                  ram_we    = 1'b1;
                  cnt_nxt   = cnt_r + CNT_W'(1);
                  tick_nxt  = '0;
                  phase_nxt = PH_MARK_S;
                end else if (32'(tick_inc) > 32'(min_gap_r)) begin
                  phase_nxt = PH_DONE_S;
                end
              end
              PH_DONE_S: begin
                if (is_mark) begin
                  tick_nxt = '0;
                end
              end
              default: begin
                phase_nxt = PH_LISTEN_S;
              end
            endcase
          end
        end
        ACT_READ: begin
          ram_re = rd_hit;
        end
        ACT_RELEASE: begin
          if (phase_r == PH_DONE_S) begin
            cnt_nxt   = '0;
            phase_nxt = PH_LISTEN_S;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Duration buffer, written with the incremented tick count.
  ipwc_ram #(
    .WIDTH (TICK_WIDTH),
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tick_inc),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_ext = 32'(cnt_nxt);
  assign rd_ext  = 32'(ram_rdata);

  // Configuration and capture control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r    <= GAP_W'(100);
      mark_level_r <= 1'b0;
      phase_r      <= PH_LISTEN_S;
      cnt_r        <= '0;
      tick_r       <= '0;
      err_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_GAP:    min_gap_r    <= cfg_wdata[GAP_W-1:0];
          CFG_MARK_LEVEL: mark_level_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      tick_r  <= tick_nxt;
      err_r   <= err_nxt;
    end
  end

  // Valid flags of the read stage and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        p_v_r <= 1'b1;
      end else if (p_adv) begin
        p_v_r <= 1'b0;
      end
      if (p_adv) begin
        o_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        o_v_r <= 1'b0;
      end
    end
  end

  // Result payload: status after the transaction, then the buffer data.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_phase_r <= phase_code(phase_nxt);
      p_cnt_r   <= cnt_ext[COUNT_W-1:0];
      p_err_r   <= err_nxt;
      p_rd_r    <= ram_re;
    end
    if (p_adv) begin
      o_phase_r <= p_phase_r;
      o_cnt_r   <= p_cnt_r;
      o_err_r   <= p_err_r;
      o_val_r   <= p_rd_r ? rd_ext[VALUE_W-1:0] : '0;
    end
  end

  assign out_ch.valid          = o_v_r;
  assign out_ch.phase          = o_phase_r;
  assign out_ch.count          = o_cnt_r;
  assign out_ch.overflow_error = o_err_r;
  assign out_ch.entry_value    = o_val_r;

  // Consistency checks on the capture state and the result pipeline.
  `IPWC_ASSERT(a_cnt_bound, clk, rst_n, 32'(cnt_r) <= 32'(BUF_DEPTH), "entry count above depth")
  `IPWC_ASSERT_IMPL(a_err_phase, clk, rst_n, err_r, !in_frame, "error flag inside an open frame")
  `IPWC_ASSERT_IMPL(a_frame_cnt, clk, rst_n, in_frame, cnt_r != '0, "open frame without gap entry")
  `IPWC_ASSERT(a_pipe_adv, clk, rst_n, (p_v_r && !o_v_r) |=> o_v_r, "read stage did not advance")

endmodule

// ===== sim/ir_pulse_width_capture_tb.sv =====
// Self-checking testbench for the infrared pulse width capture block.
`timescale 1ns / 100ps

module ir_pulse_width_capture_tb;
  import ipwc_pkg::*;

  localparam int TICK_MAX    = (1 << IPWC_TICK_WIDTH) - 1;
  localparam int QUIET_LIMIT = 2000;
  // The one action code that the block does not use.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // Status fields that the block reports for one transaction.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [COUNT_W-1:0] count;
    logic               err;
    logic [VALUE_W-1:0] value;
  } status_t;

  // Mirror of the capture state that predicts and checks every status transaction.
  class capture_scoreboard;
    logic [GAP_W-1:0]   min_gap;
    logic               mark_lvl;
    logic [PHASE_W-1:0] phase;
    int                 entries;
    int                 ticks;
    logic               err;
    logic [VALUE_W-1:0] durations [IPWC_BUF_DEPTH];
    status_t            status_queue [$];
    int                 errors;

    function new();
      min_gap  = 16'd100;
      mark_lvl = 1'b0;
      phase    = PHASE_LISTEN;
      entries  = 0;
      ticks    = 0;
      err      = 1'b0;
      errors   = 0;
      foreach (durations[i]) durations[i] = '0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_GAP:    min_gap = data[GAP_W-1:0];
        CFG_MARK_LEVEL: mark_lvl = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return status_queue.size();
    endfunction

    // Records the running tick count as the next duration and restarts the count.
    function void store_duration();
      durations[entries] = ticks[VALUE_W-1:0];
      entries++;
      ticks = 0;
    endfunction

    // One receiver sample: count it, then advance the mark/space state.
    function void apply_tick(input logic lvl);
      logic is_mark;
      is_mark = (lvl == mark_lvl);
      if (ticks < TICK_MAX) ticks++;
      // A full buffer ends the frame with the error flag, whatever the phase.
      if (entries >= IPWC_BUF_DEPTH) begin
        err   = 1'b1;
        phase = PHASE_DONE;
        return;
      end
      case (phase)
        PHASE_LISTEN: begin
          if (is_mark) begin
            if (ticks < min_gap) begin
              ticks = 0;
            end else begin
              entries = 0;
              store_duration();
              err   = 1'b0;
              phase = PHASE_MARK;
            end
          end
        end
        PHASE_MARK: begin
          if (!is_mark) begin
            store_duration();
            phase = PHASE_SPACE;
          end
        end
        PHASE_SPACE: begin
          if (is_mark) begin
            store_duration();
            phase = PHASE_MARK;
          end else if (ticks > min_gap) begin
            phase = PHASE_DONE;
          end
        end
        default: begin
          if (is_mark) ticks = 0;
        end
      endcase
    endfunction

    // Works out the status that an accepted input transaction produces.
    function void predict_status(input logic [ACTION_W-1:0] act, input logic lvl,
                                 input logic [INDEX_W-1:0] idx);
      status_t st;
      st.value = '0;
      case (act)
        ACT_TICK: apply_tick(lvl);
        ACT_READ: begin
          if (idx < entries) st.value = durations[idx];
        end
        ACT_RELEASE: begin
          if (phase == PHASE_DONE) begin
            entries = 0;
            phase   = PHASE_LISTEN;
          end
        end
        default: ;
      endcase
      st.phase = phase;
      st.count = entries[COUNT_W-1:0];
      st.err   = err;
      status_queue.push_back(st);
    endfunction

    task report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    // Compares a status transaction with the oldest prediction.
    task check_result(input status_t got);
      status_t want;
      if (status_queue.size() == 0) begin
        report_mismatch("unexpected status transaction, phase", got.phase, 0);
        return;
      end
      want = status_queue.pop_front();
      if (got.phase !== want.phase) report_mismatch("phase", got.phase, want.phase);
      if (got.count !== want.count) report_mismatch("count", got.count, want.count);
      if (got.err !== want.err) report_mismatch("overflow_error", got.err, want.err);
      if (got.value !== want.value) report_mismatch("entry_value", got.value, want.value);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ipwc_in_if  in_ch ();
  ipwc_out_if out_ch ();

  capture_scoreboard sb = new();

  int   gap_pct   = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  logic run_level = 1'b0;
  int   run_left  = 0;

  ir_pulse_width_capture u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always #2 clk = ~clk;

  // The receiving side stalls at random according to the current stall percentage.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Both channels are observed at the clock edge that completes a transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result({out_ch.phase, out_ch.count, out_ch.overflow_error,
                         out_ch.entry_value});
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.predict_status(in_ch.action, in_ch.level, in_ch.index);
      end
    end
  end

  // Ends a run that stops moving transactions.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one transaction after a random gap and returns at its acceptance edge.
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic lvl,
                           input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.level  <= lvl;
    in_ch.index  <= idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops the input and waits until every predicted status has come back.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges while the block is idle.
  task automatic set_config(input logic [GAP_W-1:0] gap, input logic lvl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    sb.write_reg(CFG_MIN_GAP, gap);
    cfg_index <= CFG_MARK_LEVEL;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, lvl};
    @(posedge clk);
    sb.write_reg(CFG_MARK_LEVEL, {{(CFG_DATA_W-1){1'b0}}, lvl});
    cfg_we <= 1'b0;
  endtask

  // Mostly runs of equal samples that form frames, mixed with reads, releases and noise.
  task automatic run_random(input int n_items, input int max_run);
    int                  pick;
    logic [ACTION_W-1:0] act;
    logic                lvl;
    logic [INDEX_W-1:0]  idx;
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        run_level = ~run_level;
        run_left  = $urandom_range(max_run, 1);
      end
      pick = $urandom_range(99);
      lvl  = 1'($urandom_range(1));
      idx  = INDEX_W'($urandom_range(127));
      act  = ACT_TICK;
      if (pick < 70) begin
        lvl = run_level;
        run_left--;
      end else if (pick < 82) begin
        act = ACT_READ;
        if ($urandom_range(3) != 0 && sb.entries > 0) begin
          idx = INDEX_W'($urandom_range(sb.entries - 1));
        end
      end else if (pick < 90) begin
        act = ACT_RELEASE;
      end else begin
        act = ACTION_W'($urandom_range(3));
      end
      send_item(act, lvl, idx);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.level  = 1'b0;
    in_ch.index  = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Status after reset, the unused action, a release while listening and a short gap.
    send_item(ACT_READ, 1'b0, 7'd0);
    send_item(ACT_UNUSED, 1'b1, 7'd127);
    send_item(ACT_RELEASE, 1'b0, 7'd0);
    send_item(ACT_TICK, 1'b0, 7'd0);
    drain_block();

    // Smallest gap: one short frame, reads around the count, releases while the frame is still open.
    set_config(16'd1, 1'b0);
    send_item(ACT_TICK, 1'b1, 7'd0);
    send_item(ACT_TICK, 1'b0, 7'd0);
    send_item(ACT_TICK, 1'b0, 7'd0);
    send_item(ACT_TICK, 1'b1, 7'd0);
    send_item(ACT_TICK, 1'b0, 7'd0);
    send_item(ACT_TICK, 1'b1, 7'd0);
    send_item(ACT_RELEASE, 1'b1, 7'd0);
    send_item(ACT_READ, 1'b0, 7'd0);
    send_item(ACT_READ, 1'b0, 7'd1);
    send_item(ACT_READ, 1'b1, 7'd3);
    send_item(ACT_READ, 1'b0, 7'd4);
    send_item(ACT_READ, 1'b1, 7'd127);
    send_item(ACT_TICK, 1'b1, 7'd0);
    send_item(ACT_TICK, 1'b0, 7'd0);
    send_item(ACT_READ, 1'b0, 7'd2);
    send_item(ACT_RELEASE, 1'b0, 7'd0);
    send_item(ACT_READ, 1'b0, 7'd0);
    send_item(ACT_UNUSED, 1'b0, 7'd0);
    drain_block();

    // Smallest gap with the level toggling every tick: each change of level stores one duration
    // until the buffer overflows, then every entry is read back.
    set_config(16'd1, 1'b0);
    for (int i = 0; i < IPWC_BUF_DEPTH + 2; i++) send_item(ACT_TICK, i[0], 7'd0);
    for (int i = 0; i < IPWC_BUF_DEPTH; i++) send_item(ACT_READ, 1'b0, i[INDEX_W-1:0]);
    send_item(ACT_RELEASE, 1'b0, 7'd0);
    send_item(ACT_READ, 1'b0, 7'd0);
    drain_block();

    // Random frames without idling.
    set_config(16'd3, 1'b1);
    run_random(50, 5);
    drain_block();

    // Random frames with the sender idle about half the time.
    gap_pct = 49;
    set_config(16'd5, 1'b0);
    run_random(50, 7);
    drain_block();

    // Short runs against a small gap while the receiver stalls about half the time.
    gap_pct   = 0;
    stall_pct = 49;
    set_config(16'd2, 1'b1);
    run_random(70, 2);
    drain_block();

    // Both sides idle now and then.
    gap_pct   = 26;
    stall_pct = 26;
    set_config(16'd1, 1'b0);
    run_random(50, 3);
    drain_block();

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
